FILE: design/crcfr_pkg.sv
// crcfr_pkg: types, codes and the crc16 step shared by the frame responder modules
// no dependencies; every other file of the block but crcfr_checker refers to it by scoped names

package crcfr_pkg;

   localparam int BYTE_W = 8;
   localparam int ERR_W  = 4;
   localparam int CRC_W  = 16;

   localparam int TICK_QUEUE_DEPTH = 2;

   // request kinds
   localparam logic [1:0] KIND_BYTE = 2'd0;
   localparam logic [1:0] KIND_GAP  = 2'd1;
   localparam logic [1:0] KIND_TICK = 2'd2;

   localparam logic [BYTE_W-1:0] HEAD_BYTE = 8'hA5;
   localparam logic [CRC_W-1:0]  CRC_INIT  = 16'hFFFF;
   localparam logic [CRC_W-1:0]  CRC_POLY  = 16'hA001;

   // command bytes of a received frame
   localparam logic [BYTE_W-1:0] CMD_STATE   = 8'h00;
   localparam logic [BYTE_W-1:0] CMD_REFUND  = 8'h01;
   localparam logic [BYTE_W-1:0] CMD_CHANNEL = 8'h02;
   localparam logic [BYTE_W-1:0] CMD_PAUSE   = 8'h03;

   // reply command bytes
   localparam logic [BYTE_W-1:0] RPL_IDLE        = 8'h80;
   localparam logic [BYTE_W-1:0] RPL_BRUSH       = 8'h81;
   localparam logic [BYTE_W-1:0] RPL_PAUSE       = 8'h82;
   localparam logic [BYTE_W-1:0] RPL_CHANNEL     = 8'h83;
   localparam logic [BYTE_W-1:0] RPL_REFUND_REQ  = 8'h84;
   localparam logic [BYTE_W-1:0] RPL_REFUND_DONE = 8'h85;
   localparam logic [BYTE_W-1:0] RPL_UNKNOWN     = 8'hF5;
   localparam logic [BYTE_W-1:0] RPL_ERR_BASE    = 8'hF0;

   localparam logic [BYTE_W-1:0] PAUSE_DELAY_RESET = 8'd100;

   typedef enum logic [2:0] {
      V_NONE  = 3'd0,
      V_RIGHT = 3'd1,
      V_LEN   = 3'd2,
      V_HEAD  = 3'd3,
      V_CRC   = 3'd4
   } verdict_type;

   // one tick as handed from the front to the back
   typedef struct packed {
      verdict_type       verdict;
      logic [BYTE_W-1:0] cmd;
      logic              brush_pending;
      logic [BYTE_W-1:0] brush_count;
      logic              refund_pending;
      logic              refund_done;
      logic [BYTE_W-1:0] refund_channel;
   } tick_entry_type;

   // one byte of modbus crc16, reflected
   function automatic logic [CRC_W-1:0] crc16_step(input logic [CRC_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] data);
      logic [CRC_W-1:0] c;
      c = crc ^ {8'h00, data};
      for (int b = 0; b < BYTE_W; b++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

FILE: design/crcfr_fifo.sv
// crcfr_fifo: short queue of tick entries between the front and the back
// depends on crcfr_pkg for the entry type and depth

module crcfr_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  crcfr_pkg::tick_entry_type push_data,
   output logic                     full,
   input  logic                     pop,
   output logic                     empty,
   output crcfr_pkg::tick_entry_type pop_data
);

   localparam int DEPTH = crcfr_pkg::TICK_QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   crcfr_pkg::tick_entry_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: design/crcfr_front.sv
// crcfr_front: collects frame bytes, checks length, head and crc at a line gap,
// and turns each tick into a queue entry; depends on crcfr_pkg

module crcfr_front #(
   parameter int FRAME_BYTES = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic [1:0]                  kind,
   input  logic [crcfr_pkg::BYTE_W-1:0] rx_byte,
   input  logic                        brush_pending,
   input  logic [crcfr_pkg::BYTE_W-1:0] brush_count,
   input  logic                        refund_pending,
   input  logic                        refund_done,
   input  logic [crcfr_pkg::BYTE_W-1:0] refund_channel,
   output logic                        busy,
   output logic                        tick_push,
   output crcfr_pkg::tick_entry_type   tick_entry
);

   localparam int IDX_W = $clog2(FRAME_BYTES);
   localparam int CNT_W = $clog2(FRAME_BYTES + 1);

   typedef enum logic {
      ST_IDLE,
      ST_CHECK
   } state_type;

   state_type                        state_ff;
   logic [CNT_W-1:0]                 count_ff;
   crcfr_pkg::verdict_type           verdict_ff;
   logic [crcfr_pkg::CRC_W-1:0]      crc_ff, crc_in;
   logic [IDX_W-1:0]                 idx_ff;
   logic [crcfr_pkg::BYTE_W-1:0]     frame_ff [FRAME_BYTES];
   logic                             room;
   logic                             crc_match;

   assign busy      = (state_ff == ST_CHECK);
   assign room      = (count_ff < CNT_W'(FRAME_BYTES));
   assign tick_push = accept && (kind == crcfr_pkg::KIND_TICK);

   assign crc_in    = crcfr_pkg::crc16_step(crc_ff, frame_ff[idx_ff]);
   // received crc arrives low byte first
   assign crc_match = (crc_in == {frame_ff[FRAME_BYTES-1], frame_ff[FRAME_BYTES-2]});

   always_comb begin
      tick_entry.verdict        = verdict_ff;
      tick_entry.cmd            = frame_ff[1];
      tick_entry.brush_pending  = brush_pending;
      tick_entry.brush_count    = brush_count;
      tick_entry.refund_pending = refund_pending;
      tick_entry.refund_done    = refund_done;
      tick_entry.refund_channel = refund_channel;
   end

   always_ff @(posedge clock) begin
      if (accept && (kind == crcfr_pkg::KIND_BYTE) && room) begin
         frame_ff[count_ff[IDX_W-1:0]] <= rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         verdict_ff <= crcfr_pkg::V_NONE;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (kind == crcfr_pkg::KIND_BYTE) begin
                     if (room) begin
                        count_ff <= count_ff + 1'b1;
                     end
                  end else if (kind == crcfr_pkg::KIND_GAP) begin
                     count_ff <= '0;
                     if (room) begin
                        verdict_ff <= crcfr_pkg::V_LEN;
                     end else if (frame_ff[0] != crcfr_pkg::HEAD_BYTE) begin
                        verdict_ff <= crcfr_pkg::V_HEAD;
                     end else begin
                        crc_ff   <= crcfr_pkg::CRC_INIT;
                        idx_ff   <= '0;
                        state_ff <= ST_CHECK;
                     end
                  end else if (kind == crcfr_pkg::KIND_TICK) begin
                     verdict_ff <= crcfr_pkg::V_NONE;
                  end
               end
            end
            ST_CHECK: begin
               // one buffered byte per cycle through the crc
               crc_ff <= crc_in;
               idx_ff <= idx_ff + 1'b1;
               if (idx_ff == IDX_W'(FRAME_BYTES - 3)) begin
                  verdict_ff <= crc_match ? crcfr_pkg::V_RIGHT : crcfr_pkg::V_CRC;
                  state_ff   <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

FILE: design/crcfr_back.sv
// crcfr_back: takes tick entries, updates the error and pause counters and
// sends the reply frame or a status item; depends on crcfr_pkg

module crcfr_back #(
   parameter int FRAME_BYTES = 8,
   parameter int ERROR_CAP   = 10
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         queue_empty,
   input  crcfr_pkg::tick_entry_type    entry,
   output logic                         queue_pop,
   input  logic                         csr_write_enable,
   input  logic [crcfr_pkg::BYTE_W-1:0] csr_write_data,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output logic                         rsp_tx_valid,
   output logic [crcfr_pkg::BYTE_W-1:0] rsp_tx_byte,
   output logic                         rsp_tx_last,
   output logic                         rsp_clear_brush,
   output logic [crcfr_pkg::ERR_W-1:0]  rsp_error_level,
   output logic [crcfr_pkg::BYTE_W-1:0] rsp_pause_remaining
);

   localparam int IDX_W = $clog2(FRAME_BYTES);
   localparam int BW    = crcfr_pkg::BYTE_W;
   localparam int EW    = crcfr_pkg::ERR_W;

   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } state_type;

   state_type                   state_ff;
   logic                        out_valid_ff, out_valid_in;
   logic [EW-1:0]               err_ff, err_in;
   logic [BW-1:0]               pause_ff, pause_in;
   logic [BW-1:0]               pause_delay_ff;
   logic [BW-1:0]               cmd_ff, cmd_in;
   logic [BW-1:0]               data0_ff, data0_in;
   logic                        clr_ff, clr_in;
   logic [IDX_W-1:0]            idx_ff;
   logic [crcfr_pkg::CRC_W-1:0] crc_ff;
   logic                        can_load;
   logic                        out_load;
   logic                        last_byte;
   logic [EW:0]                 err_sum;
   logic [BW-1:0]               pause_base;
   logic [BW-1:0]               byte_cur;
   logic [BW-1:0]               tx_byte_ff;
   logic                        tx_last_ff;
   logic                        tx_flag_ff;
   logic                        clear_ff;
   logic [EW-1:0]               err_out_ff;
   logic [BW-1:0]               pause_out_ff;

   assign can_load  = !out_valid_ff || rsp_pop;
   assign queue_pop = (state_ff == ST_IDLE) && !queue_empty && can_load;
   assign last_byte = (idx_ff == IDX_W'(FRAME_BYTES - 1));

   // output register fills on a status item or a reply byte, empties on pop
   assign out_load     = (queue_pop && (entry.verdict == crcfr_pkg::V_NONE))
                         || ((state_ff == ST_EMIT) && can_load);
   assign out_valid_in = out_load || (out_valid_ff && !rsp_pop);

   assign rsp_empty           = !out_valid_ff;
   assign rsp_tx_valid        = tx_flag_ff;
   assign rsp_tx_byte         = tx_byte_ff;
   assign rsp_tx_last         = tx_last_ff;
   assign rsp_clear_brush     = clear_ff;
   assign rsp_error_level     = err_out_ff;
   assign rsp_pause_remaining = pause_out_ff;

   // verdict decode and counter updates for the entry at the head of the queue
   always_comb begin
      err_sum    = {1'b0, err_ff} + (EW + 1)'(2);
      err_in     = err_ff;
      cmd_in     = crcfr_pkg::RPL_IDLE;
      data0_in   = '0;
      clr_in     = 1'b0;
      pause_base = pause_ff;
      if (entry.verdict == crcfr_pkg::V_RIGHT) begin
         err_in = (err_ff != '0) ? err_ff - 1'b1 : err_ff;
         unique case (entry.cmd)
            crcfr_pkg::CMD_STATE: begin
               if (entry.brush_pending) begin
                  cmd_in   = crcfr_pkg::RPL_BRUSH;
                  data0_in = entry.brush_count;
               end else if (entry.refund_pending) begin
                  cmd_in = crcfr_pkg::RPL_REFUND_REQ;
               end else begin
                  cmd_in = crcfr_pkg::RPL_IDLE;
               end
            end
            crcfr_pkg::CMD_REFUND: begin
               cmd_in = entry.refund_done ? crcfr_pkg::RPL_REFUND_DONE
                                          : crcfr_pkg::RPL_IDLE;
            end
            crcfr_pkg::CMD_CHANNEL: begin
               cmd_in   = crcfr_pkg::RPL_CHANNEL;
               data0_in = entry.refund_channel;
               clr_in   = 1'b1;
            end
            crcfr_pkg::CMD_PAUSE: begin
               cmd_in     = crcfr_pkg::RPL_PAUSE;
               pause_base = pause_delay_ff;
            end
            default: cmd_in = crcfr_pkg::RPL_UNKNOWN;
         endcase
      end else if (entry.verdict != crcfr_pkg::V_NONE) begin
         cmd_in = crcfr_pkg::RPL_ERR_BASE | BW'(entry.verdict);
         err_in = (err_sum >= (EW + 1)'(ERROR_CAP)) ? EW'(ERROR_CAP) : err_sum[EW-1:0];
      end
      pause_in = (pause_base != '0) ? pause_base - 1'b1 : pause_base;
   end

   // reply byte at the current position
   always_comb begin
      priority if (idx_ff == IDX_W'(FRAME_BYTES - 1)) begin
         byte_cur = crc_ff[15:8];
      end else if (idx_ff == IDX_W'(FRAME_BYTES - 2)) begin
         byte_cur = crc_ff[7:0];
      end else if (idx_ff == '0) begin
         byte_cur = crcfr_pkg::HEAD_BYTE;
      end else if (idx_ff == IDX_W'(1)) begin
         byte_cur = cmd_ff;
      end else if (idx_ff == IDX_W'(2)) begin
         byte_cur = data0_ff;
      end else begin
         byte_cur = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         out_valid_ff   <= 1'b0;
         err_ff         <= '0;
         pause_ff       <= '0;
         pause_delay_ff <= crcfr_pkg::PAUSE_DELAY_RESET;
      end else begin
         out_valid_ff <= out_valid_in;
         if (csr_write_enable) begin
            pause_delay_ff <= csr_write_data;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (queue_pop) begin
                  err_ff   <= err_in;
                  pause_ff <= pause_in;
                  if (entry.verdict == crcfr_pkg::V_NONE) begin
                     tx_flag_ff   <= 1'b0;
                     tx_byte_ff   <= '0;
                     tx_last_ff   <= 1'b1;
                     clear_ff     <= 1'b0;
                     err_out_ff   <= err_in;
                     pause_out_ff <= pause_in;
                  end else begin
                     cmd_ff   <= cmd_in;
                     data0_ff <= data0_in;
                     clr_ff   <= clr_in;
                     idx_ff   <= '0;
                     crc_ff   <= crcfr_pkg::CRC_INIT;
                     state_ff <= ST_EMIT;
                  end
               end
            end
            ST_EMIT: begin
               if (can_load) begin
                  tx_flag_ff   <= 1'b1;
                  tx_byte_ff   <= byte_cur;
                  tx_last_ff   <= last_byte;
                  clear_ff     <= clr_ff;
                  err_out_ff   <= err_ff;
                  pause_out_ff <= pause_ff;
                  // crc runs over everything before the two crc bytes
                  if (idx_ff < IDX_W'(FRAME_BYTES - 2)) begin
                     crc_ff <= crcfr_pkg::crc16_step(crc_ff, byte_cur);
                  end
                  idx_ff <= idx_ff + 1'b1;
                  if (last_byte) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

FILE: design/crc_checked_frame_responder_core.sv
// Frame responder with crc check: receives request items on a queue-style input
// (req_push / req_full) and hands result items out on a queue-style output
// (rsp_empty / rsp_pop); pause_delay is written through csr_write_enable/data.
// A request is a received byte, a line gap that closes the frame, or a tick.
// A byte is stored in the frame buffer while it has room. A gap after a full frame
// with a good head byte holds req_full high while the frame crc is worked out
// one byte per cycle; other gaps do not raise req_full.
// A tick is queued (two deep) and the back end answers it: a status item goes into
// the output register when the back end pops the tick, the first reply byte once
// it has moved to its emit state; a reply frame then gives one byte per cycle while
// rsp_pop keeps up. The reply crc is computed as the bytes go out.
// If the receiver stalls, the output register holds its item, the back end
// waits, and the input keeps taking bytes and gaps until the tick queue fills.
// Reset (synchronous) empties the queue and output, clears the byte count,
// pending verdict, error and pause counters and sets pause_delay to 100; the
// frame buffer keeps whatever it held.
// Depends on crcfr_pkg, crcfr_front, crcfr_fifo and crcfr_back.

module crc_checked_frame_responder_core #(
   parameter int FRAME_BYTES = 8,
   parameter int ERROR_CAP   = 10
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [1:0] req_kind,
   input  logic [7:0] req_rx_byte,
   input  logic       req_brush_pending,
   input  logic [7:0] req_brush_count,
   input  logic       req_refund_pending,
   input  logic       req_refund_done,
   input  logic [7:0] req_refund_channel,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic       rsp_tx_valid,
   output logic [7:0] rsp_tx_byte,
   output logic       rsp_tx_last,
   output logic       rsp_clear_brush,
   output logic [3:0] rsp_error_level,
   output logic [7:0] rsp_pause_remaining,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data
);

   logic                      front_busy;
   logic                      req_accept;
   logic                      tick_push;
   crcfr_pkg::tick_entry_type tick_entry;
   crcfr_pkg::tick_entry_type head_entry;
   logic                      queue_full;
   logic                      queue_empty;
   logic                      queue_pop;

   assign req_full   = front_busy || queue_full;
   assign req_accept = req_push && !req_full;

   crcfr_front #(
      .FRAME_BYTES(FRAME_BYTES)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (req_accept),
      .kind           (req_kind),
      .rx_byte        (req_rx_byte),
      .brush_pending  (req_brush_pending),
      .brush_count    (req_brush_count),
      .refund_pending (req_refund_pending),
      .refund_done    (req_refund_done),
      .refund_channel (req_refund_channel),
      .busy           (front_busy),
      .tick_push      (tick_push),
      .tick_entry     (tick_entry)
   );

   crcfr_fifo u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (tick_push),
      .push_data (tick_entry),
      .full      (queue_full),
      .pop       (queue_pop),
      .empty     (queue_empty),
      .pop_data  (head_entry)
   );

   crcfr_back #(
      .FRAME_BYTES(FRAME_BYTES),
      .ERROR_CAP  (ERROR_CAP)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .queue_empty         (queue_empty),
      .entry               (head_entry),
      .queue_pop           (queue_pop),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_tx_valid        (rsp_tx_valid),
      .rsp_tx_byte         (rsp_tx_byte),
      .rsp_tx_last         (rsp_tx_last),
      .rsp_clear_brush     (rsp_clear_brush),
      .rsp_error_level     (rsp_error_level),
      .rsp_pause_remaining (rsp_pause_remaining)
   );

endmodule

FILE: design/crcfr_checker.sv
// crcfr_checker: port-level assertions for the frame responder, bound to the top
// depends on crc_checked_frame_responder_core for the bind target

module crcfr_checker #(
   parameter int ERROR_CAP = 10
) (
   input logic       clock,
   input logic       reset,
   input logic       req_full,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input logic       rsp_tx_valid,
   input logic [7:0] rsp_tx_byte,
   input logic       rsp_tx_last,
   input logic       rsp_clear_brush,
   input logic [3:0] rsp_error_level
);

   // after reset nothing is waiting and requests are taken
   a_reset_idle: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("output not empty or input full after reset");

   // a waiting result holds until it is popped
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_tx_byte)
                                 && $stable(rsp_tx_last) && $stable(rsp_tx_valid))
      else $error("waiting result changed before pop");

   a_err_cap: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_error_level <= 4'(ERROR_CAP))
      else $error("error level above cap");

   // a status item stands alone with no frame content
   a_status_shape: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_tx_valid |-> rsp_tx_last && rsp_tx_byte == 8'h00
                                      && !rsp_clear_brush)
      else $error("malformed status item");

   // reply bytes follow each other without a gap
   a_frame_continues: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_pop && rsp_tx_valid && !rsp_tx_last |=> !rsp_empty && rsp_tx_valid)
      else $error("gap inside reply frame");

endmodule

bind crc_checked_frame_responder_core crcfr_checker #(
   .ERROR_CAP(ERROR_CAP)
) u_checker (
   .clock           (clock),
   .reset           (reset),
   .req_full        (req_full),
   .rsp_empty       (rsp_empty),
   .rsp_pop         (rsp_pop),
   .rsp_tx_valid    (rsp_tx_valid),
   .rsp_tx_byte     (rsp_tx_byte),
   .rsp_tx_last     (rsp_tx_last),
   .rsp_clear_brush (rsp_clear_brush),
   .rsp_error_level (rsp_error_level)
);

FILE: tb/sv/tb_top.sv
// tb_top: self-checking testbench of crc_checked_frame_responder_core
// clocked driver and monitor around the core, with a request-level predictor of the replies
// depends on crcfr_pkg and the core

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAME_BYTES  = 8;
   localparam int ERROR_CAP    = 10;
   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int DRAIN_CYCLES = 30;
   localparam int HOLD_CYCLES  = 500;
   localparam int MAX_REPORTS  = 10;

   typedef logic [FRAME_BYTES-1:0][7:0] frame_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] rx_byte;
      logic       brush_pending;
      logic [7:0] brush_count;
      logic       refund_pending;
      logic       refund_done;
      logic [7:0] refund_channel;
   } request_type;

   typedef struct packed {
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       tx_last;
      logic       clear_brush;
      logic [3:0] error_level;
      logic [7:0] pause_remaining;
   } reply_type;

   typedef enum int {FLAW_NONE, FLAW_HEAD, FLAW_CRC, FLAW_SHORT, FLAW_LONG} frame_flaw_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   request_type req_drive = '0;
   logic        rsp_pop = 1'b0;
   logic        csr_write_enable = 1'b0;
   logic [7:0]  csr_write_data = 8'd0;

   logic       req_full;
   logic       rsp_empty;
   logic       rsp_tx_valid;
   logic [7:0] rsp_tx_byte;
   logic       rsp_tx_last;
   logic       rsp_clear_brush;
   logic [3:0] rsp_error_level;
   logic [7:0] rsp_pause_remaining;

   request_type pending_requests[$];
   reply_type   expected_replies[$];

   // predictor state
   frame_type              rx_frame;
   int                     rx_count;
   crcfr_pkg::verdict_type pend_verdict;
   logic [3:0]             err_level;
   logic [7:0]             pause_left;
   logic [7:0]             pause_delay_model;

   int       send_idle_pct = 0;
   int       recv_idle_pct = 0;
   int       traffic_phase = 0;
   int       mismatch_count = 0;
   int       stim_count = 0;
   logic     rx_hold = 1'b0;
   logic     push_taken = 1'b0;

   crc_checked_frame_responder_core #(
      .FRAME_BYTES(FRAME_BYTES),
      .ERROR_CAP  (ERROR_CAP)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_kind           (req_drive.kind),
      .req_rx_byte        (req_drive.rx_byte),
      .req_brush_pending  (req_drive.brush_pending),
      .req_brush_count    (req_drive.brush_count),
      .req_refund_pending (req_drive.refund_pending),
      .req_refund_done    (req_drive.refund_done),
      .req_refund_channel (req_drive.refund_channel),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_tx_valid       (rsp_tx_valid),
      .rsp_tx_byte        (rsp_tx_byte),
      .rsp_tx_last        (rsp_tx_last),
      .rsp_clear_brush    (rsp_clear_brush),
      .rsp_error_level    (rsp_error_level),
      .rsp_pause_remaining(rsp_pause_remaining),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   function automatic logic [15:0] modbus_crc(input frame_type bytes, input int n);
      logic [15:0] acc;
      int          i;
      acc = crcfr_pkg::CRC_INIT;
      for (i = 0; i < n; i++) begin
         acc = acc ^ {8'h00, bytes[i]};
         repeat (8) acc = acc[0] ? ((acc >> 1) ^ crcfr_pkg::CRC_POLY) : (acc >> 1);
      end
      return acc;
   endfunction

   // biased towards the two extremes
   function automatic logic [7:0] edge_byte();
      int roll;
      roll = $urandom_range(7);
      if (roll == 0) return 8'h00;
      else if (roll == 1) return 8'hFF;
      else return 8'($urandom_range(255));
   endfunction

   function automatic logic [7:0] pick_command();
      int roll;
      roll = $urandom_range(9);
      if (roll < 2) return crcfr_pkg::CMD_STATE;
      else if (roll < 4) return crcfr_pkg::CMD_REFUND;
      else if (roll < 6) return crcfr_pkg::CMD_CHANNEL;
      else if (roll < 8) return crcfr_pkg::CMD_PAUSE;
      else if (roll == 8) return 8'hFF;
      else return 8'($urandom_range(4, 254));
   endfunction

   function automatic frame_flaw_type pick_flaw();
      int roll;
      roll = $urandom_range(99);
      if (roll < 62) return FLAW_NONE;
      else if (roll < 71) return FLAW_HEAD;
      else if (roll < 82) return FLAW_CRC;
      else if (roll < 91) return FLAW_SHORT;
      else return FLAW_LONG;
   endfunction

   task automatic add_request(input logic [1:0] kind, input logic [7:0] data);
      request_type r;
      r.kind           = kind;
      r.rx_byte        = data;
      r.brush_pending  = 1'($urandom_range(1));
      r.brush_count    = edge_byte();
      r.refund_pending = 1'($urandom_range(1));
      r.refund_done    = 1'($urandom_range(1));
      r.refund_channel = edge_byte();
      pending_requests.push_back(r);
      if (kind != KIND_UNUSED) stim_count++;
   endtask

   // frame bytes only; the caller adds the closing gap
   task automatic add_frame(input logic [7:0] cmd, input frame_flaw_type flaw);
      frame_type   f;
      logic [15:0] c;
      int          n;
      int          i;
      int          idx;
      f[0] = crcfr_pkg::HEAD_BYTE;
      f[1] = cmd;
      for (i = 2; i < FRAME_BYTES - 2; i++) f[i] = edge_byte();
      c = modbus_crc(f, FRAME_BYTES - 2);
      f[FRAME_BYTES-2] = c[7:0];
      f[FRAME_BYTES-1] = c[15:8];
      n = FRAME_BYTES;
      case (flaw)
         FLAW_HEAD: f[0] = f[0] ^ 8'($urandom_range(1, 255));
         FLAW_CRC: begin
            idx = $urandom_range(1, FRAME_BYTES - 1);
            f[idx] = f[idx] ^ (8'd1 << $urandom_range(7));
         end
         FLAW_SHORT: n = $urandom_range(0, FRAME_BYTES - 1);
         default: ;
      endcase
      for (i = 0; i < n; i++) add_request(crcfr_pkg::KIND_BYTE, f[i]);
      if (flaw == FLAW_LONG) begin
         n = $urandom_range(1, 3);
         for (i = 0; i < n; i++) add_request(crcfr_pkg::KIND_BYTE, edge_byte());
      end
   endtask

   task automatic add_random_traffic(input int amount);
      int         target;
      int         roll;
      int         n;
      int         i;
      logic [1:0] kind;
      target = stim_count + amount;
      while (stim_count < target) begin
         if ($urandom_range(99) < 75) begin
            add_frame(pick_command(), pick_flaw());
            add_request(crcfr_pkg::KIND_GAP, edge_byte());
            if ($urandom_range(24) == 0) add_request(crcfr_pkg::KIND_GAP, edge_byte());
            // now and then a byte or two slips in before the tick
            n = ($urandom_range(14) == 0) ? int'($urandom_range(1, 2)) : 0;
            for (i = 0; i < n; i++) add_request(crcfr_pkg::KIND_BYTE, edge_byte());
            add_request(crcfr_pkg::KIND_TICK, edge_byte());
            if (n != 0) add_request(crcfr_pkg::KIND_GAP, edge_byte());
            if ($urandom_range(3) == 0) add_request(crcfr_pkg::KIND_TICK, edge_byte());
         end else begin
            n = $urandom_range(1, 4);
            for (i = 0; i < n; i++) begin
               roll = $urandom_range(15);
               if (roll == 0) kind = KIND_UNUSED;
               else if (roll < 8) kind = crcfr_pkg::KIND_BYTE;
               else if (roll < 11) kind = crcfr_pkg::KIND_GAP;
               else kind = crcfr_pkg::KIND_TICK;
               add_request(kind, edge_byte());
            end
            add_request(crcfr_pkg::KIND_GAP, edge_byte());
         end
      end
   endtask

   task automatic predict_request(input request_type r);
      frame_type   reply;
      logic [15:0] c;
      logic [7:0]  data0;
      logic        clr;
      logic        with_frame;
      reply_type   it;
      int          k;
      case (r.kind)
         crcfr_pkg::KIND_BYTE: begin
            if (rx_count < FRAME_BYTES) begin
               rx_frame[rx_count] = r.rx_byte;
               rx_count++;
            end
         end
         crcfr_pkg::KIND_GAP: begin
            if (rx_count < FRAME_BYTES) begin
               pend_verdict = crcfr_pkg::V_LEN;
            end else if (rx_frame[0] != crcfr_pkg::HEAD_BYTE) begin
               pend_verdict = crcfr_pkg::V_HEAD;
            end else begin
               c = modbus_crc(rx_frame, FRAME_BYTES - 2);
               pend_verdict = (c == {rx_frame[FRAME_BYTES-1], rx_frame[FRAME_BYTES-2]}) ?
                              crcfr_pkg::V_RIGHT : crcfr_pkg::V_CRC;
            end
            rx_count = 0;
         end
         crcfr_pkg::KIND_TICK: begin
            with_frame = 1'b0;
            clr = 1'b0;
            reply = '0;
            if (pend_verdict != crcfr_pkg::V_NONE) begin
               reply[0] = crcfr_pkg::HEAD_BYTE;
               data0 = 8'h00;
               if (pend_verdict != crcfr_pkg::V_RIGHT) begin
                  reply[1] = crcfr_pkg::RPL_ERR_BASE + {5'd0, pend_verdict};
                  if (err_level + 2 >= ERROR_CAP) err_level = 4'(ERROR_CAP);
                  else err_level = err_level + 4'd2;
               end else begin
                  if (err_level != 4'd0) err_level = err_level - 4'd1;
                  case (rx_frame[1])
                     crcfr_pkg::CMD_STATE: begin
                        if (r.brush_pending) begin
                           reply[1] = crcfr_pkg::RPL_BRUSH;
                           data0 = r.brush_count;
                        end else if (r.refund_pending) begin
                           reply[1] = crcfr_pkg::RPL_REFUND_REQ;
                        end else begin
                           reply[1] = crcfr_pkg::RPL_IDLE;
                        end
                     end
                     crcfr_pkg::CMD_REFUND: begin
                        reply[1] = r.refund_done ? crcfr_pkg::RPL_REFUND_DONE
                                                 : crcfr_pkg::RPL_IDLE;
                     end
                     crcfr_pkg::CMD_CHANNEL: begin
                        reply[1] = crcfr_pkg::RPL_CHANNEL;
                        data0 = r.refund_channel;
                        clr = 1'b1;
                     end
                     crcfr_pkg::CMD_PAUSE: begin
                        reply[1] = crcfr_pkg::RPL_PAUSE;
                        pause_left = pause_delay_model;
                     end
                     default: reply[1] = crcfr_pkg::RPL_UNKNOWN;
                  endcase
                  reply[2] = data0;
               end
               c = modbus_crc(reply, FRAME_BYTES - 2);
               reply[FRAME_BYTES-2] = c[7:0];
               reply[FRAME_BYTES-1] = c[15:8];
               pend_verdict = crcfr_pkg::V_NONE;
               with_frame = 1'b1;
            end
            if (pause_left != 8'd0) pause_left = pause_left - 8'd1;
            if (with_frame) begin
               for (k = 0; k < FRAME_BYTES; k++) begin
                  it.tx_valid        = 1'b1;
                  it.tx_byte         = reply[k];
                  it.tx_last         = (k == FRAME_BYTES - 1);
                  it.clear_brush     = clr;
                  it.error_level     = err_level;
                  it.pause_remaining = pause_left;
                  expected_replies.push_back(it);
               end
            end else begin
               it.tx_valid        = 1'b0;
               it.tx_byte         = 8'h00;
               it.tx_last         = 1'b1;
               it.clear_brush     = 1'b0;
               it.error_level     = err_level;
               it.pause_remaining = pause_left;
               expected_replies.push_back(it);
            end
         end
         default: ;
      endcase
   endtask

   task automatic check_reply();
      reply_type want;
      if (expected_replies.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("%0t: reply with none outstanding: v%0b %02h l%0b c%0b e%0d p%0d",
                     $time, rsp_tx_valid, rsp_tx_byte, rsp_tx_last, rsp_clear_brush,
                     rsp_error_level, rsp_pause_remaining);
      end else begin
         want = expected_replies.pop_front();
         if (rsp_tx_valid !== want.tx_valid || rsp_tx_byte !== want.tx_byte ||
             rsp_tx_last !== want.tx_last || rsp_clear_brush !== want.clear_brush ||
             rsp_error_level !== want.error_level ||
             rsp_pause_remaining !== want.pause_remaining) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("%0t: reply mismatch, expected v%0b %02h l%0b c%0b e%0d p%0d, got %s",
                        $time, want.tx_valid, want.tx_byte, want.tx_last, want.clear_brush,
                        want.error_level, want.pause_remaining,
                        $sformatf("v%0b %02h l%0b c%0b e%0d p%0d", rsp_tx_valid,
                                  rsp_tx_byte, rsp_tx_last, rsp_clear_brush,
                                  rsp_error_level, rsp_pause_remaining));
         end
      end
   endtask

   // returns at a falling edge once every request is taken and answered
   task automatic wait_drained();
      while (pending_requests.size() != 0 || expected_replies.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_pause_delay(input logic [7:0] value);
      csr_write_data   <= value;
      csr_write_enable <= 1'b1;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // driver: a request offered stays on the pins until it is taken
   always @(negedge clock) begin
      if (reset || pending_requests.size() == 0) begin
         req_push <= 1'b0;
      end else if (req_push && !push_taken) begin
         req_push <= 1'b1;
      end else if ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
      end else begin
         req_push  <= 1'b1;
         req_drive <= pending_requests[0];
      end
   end

   always @(negedge clock) begin
      if (reset || rx_hold) begin
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // monitor: pre-edge values of both channels
   always @(posedge clock) begin
      if (reset) begin
         rx_count          = 0;
         pend_verdict      = crcfr_pkg::V_NONE;
         err_level         = 4'd0;
         pause_left        = 8'd0;
         pause_delay_model = crcfr_pkg::PAUSE_DELAY_RESET;
         push_taken        = 1'b0;
      end else begin
         if (csr_write_enable) pause_delay_model = csr_write_data;
         push_taken = req_push && !req_full;
         if (push_taken) begin
            predict_request(req_drive);
            void'(pending_requests.pop_front());
         end
         if (rsp_pop && !rsp_empty) check_reply();
      end
   end

   // long receiver hold-off in the last phase so the input backs up
   initial begin
      while (traffic_phase != 3) @(negedge clock);
      repeat (40) @(negedge clock);
      rx_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(negedge clock);
      rx_hold <= 1'b0;
   end

   initial begin
      add_request(crcfr_pkg::KIND_TICK, 8'hFF);      // nothing pending: status item
      add_request(KIND_UNUSED, 8'hFF);
      add_request(crcfr_pkg::KIND_GAP, 8'h00);       // gap with no bytes
      add_request(crcfr_pkg::KIND_GAP, 8'hFF);       // replaces the pending verdict
      add_request(crcfr_pkg::KIND_TICK, 8'h00);
      add_frame(crcfr_pkg::CMD_PAUSE, FLAW_LONG);    // bytes past the frame are dropped
      add_request(crcfr_pkg::KIND_GAP, 8'h00);
      add_request(crcfr_pkg::KIND_BYTE, 8'h00);      // bytes between gap and tick
      add_request(crcfr_pkg::KIND_BYTE, crcfr_pkg::CMD_CHANNEL);
      add_request(crcfr_pkg::KIND_TICK, 8'h00);      // answers the command byte held now
      add_request(crcfr_pkg::KIND_GAP, 8'h00);
      add_request(crcfr_pkg::KIND_TICK, 8'h00);
      add_request(crcfr_pkg::KIND_TICK, 8'h00);

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      wait_drained();
      write_pause_delay(8'd0);
      send_idle_pct = 22;
      recv_idle_pct = 72;
      traffic_phase = 1;
      add_random_traffic(150);

      wait_drained();
      write_pause_delay(8'd255);
      send_idle_pct = 72;
      recv_idle_pct = 22;
      traffic_phase = 2;
      add_random_traffic(150);

      wait_drained();
      write_pause_delay(8'($urandom_range(1, 254)));
      send_idle_pct = 0;
      recv_idle_pct = 0;
      traffic_phase = 3;
      add_random_traffic(160);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_replies.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

FILE: files.f
design/crcfr_pkg.sv
design/crcfr_fifo.sv
design/crcfr_front.sv
design/crcfr_back.sv
design/crc_checked_frame_responder_core.sv
design/crcfr_checker.sv
tb/sv/tb_top.sv
